// ----- src/ersg_pkg.sv -----
// ersg_pkg: shared types and constants for the echo range servo gauge
// no dependencies; imported by ersg_servo and echo_range_servo_gauge
`timescale 1ns / 1ps

package ersg_pkg;

   localparam int unsigned TIME_W     = 16;
   localparam int unsigned PULSE_W    = 12;
   localparam int unsigned STEP_W     = 10;
   localparam int unsigned CM_W       = 11;
   localparam int unsigned NEAR_W     = 8;
   localparam int unsigned BAR_W      = 8;
   localparam int unsigned PROD_W     = NEAR_W + PULSE_W;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 12;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 48;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MAX = 2'd2;

   localparam logic [STEP_W-1:0]  SLEW_STEP_RESET = 10'd20;
   localparam logic [PULSE_W-1:0] PULSE_MIN_RESET = 12'd1000;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RESET = 12'd2000;
   localparam logic [PULSE_W-1:0] MID_PULSE       = 12'd1500;

   localparam logic [NEAR_W-1:0] FULL_CM    = 8'd200;
   localparam int unsigned       US_PER_CM  = 58;

   // w / 58 == (w * 72316) >> 22 for any 16-bit w
   localparam logic [16:0] CM_RECIP  = 17'd72316;
   localparam int unsigned CM_SHIFT  = 22;
   // x / 25 == (x * 41) >> 10 for x up to 200 (8 leds over 200 cm)
   localparam logic [5:0]  BAR_RECIP = 6'd41;
   localparam int unsigned BAR_SHIFT = 10;
   // p / 200 == (p * 671089) >> 27 for p up to 200 * 4095
   localparam logic [19:0] TGT_RECIP = 20'd671089;
   localparam int unsigned TGT_SHIFT = 27;

   typedef enum logic {
      REQ_ECHO  = 1'b0,
      REQ_FRAME = 1'b1
   } req_kind_type;

   // what an item does once it is in the pipeline
   typedef enum logic [2:0] {
      OP_RISE  = 3'b001,
      OP_FALL  = 3'b010,
      OP_FRAME = 3'b100
   } op_type;

   typedef struct packed {
      logic                 load;
      op_type               op;
      logic [PULSE_W-1:0]   target;
   } servo_ctl_type;

endpackage

// ----- src/echo_range_servo_gauge.sv -----
// echo_range_servo_gauge: top level, echo width to distance, bar and servo target
// depends on ersg_pkg and ersg_servo
`timescale 1ns / 1ps

// usage
// - req channel: one item per echo edge (tuser 0) or servo frame tick (tuser 1);
//   a rising edge stores its capture time, a falling edge measures the pulse width,
//   the distance (width / 58 cm), the led bar and a new servo target
// - rsp channel: exactly one item per request item, in order, carrying the servo
//   pulse, last echo width, last distance, bar leds and a new-echo flag in tuser
// - csr port: slew_step, pulse_min, pulse_max; write only while no item is in flight
// - pipeline: an accepted req item passes the input register, two math stages and
//   the result register before rsp valid; throughput one item per cycle while
//   rsp_tready is high, set by the pipeline that spreads its multiplies over the stages
// - reset: pipeline empty, servo pulse and target at 1500 us, width, distance
//   and bar cleared, registers at 20, 1000 and 2000
// - stall: when rsp_tready is low the result holds and the stages behind it
//   keep filling; req_tready drops only once all four stages hold items
module echo_range_servo_gauge (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: capture_time[15:0], echo_level[16], zero fill up to bit 23
   input  logic [ersg_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: req_type[0]
   input  logic [0:0]                        req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata: servo_pulse[11:0], echo_width[27:12], distance_cm[38:28],
   //            bar_leds[46:39], zero fill bit 47
   output logic [ersg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: new_echo[0]
   output logic [0:0]                        rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [ersg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ersg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ersg_pkg::*;

   // configuration registers
   logic [STEP_W-1:0]  slew_step_ff, slew_step_in;
   logic [PULSE_W-1:0] pulse_min_ff, pulse_min_in;
   logic [PULSE_W-1:0] pulse_max_ff, pulse_max_in;

   // stage valids and moves
   logic s0_v_ff, s0_v_in, s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic rsp_v_ff, rsp_v_in;
   logic req_fire, s1_load, s2_load, out_load;

   // stage 0: the accepted item
   op_type            s0_op_ff, s0_op_in;
   logic [TIME_W-1:0] s0_time_ff;

   // stage 1: width and distance
   op_type            s1_op_ff;
   logic [TIME_W-1:0] s1_width_ff;
   logic [CM_W-1:0]   s1_cm_ff;

   // stage 2: bar and scaled span product
   op_type            s2_op_ff;
   logic [TIME_W-1:0] s2_width_ff;
   logic [CM_W-1:0]   s2_cm_ff;
   logic [BAR_W-1:0]  s2_bar_ff;
   logic [PROD_W-1:0] s2_prod_ff;

   // architectural state, also the result payload
   logic [TIME_W-1:0] rise_stamp_ff, rise_stamp_in;
   logic [TIME_W-1:0] last_width_ff, last_width_in;
   logic [CM_W-1:0]   last_distance_ff, last_distance_in;
   logic [BAR_W-1:0]  last_bar_ff, last_bar_in;
   logic              new_echo_ff, new_echo_in;
   logic [PULSE_W-1:0] pulse_now;

   // math
   logic [TIME_W-1:0]         width;
   logic [TIME_W+16:0]        cm_prod;
   logic [CM_W-1:0]           cm;
   logic [NEAR_W-1:0]         near_cm;
   logic [NEAR_W-1:0]         far_cm;
   logic [PULSE_W-1:0]        span;
   logic [PROD_W-1:0]         prod;
   logic [NEAR_W+5:0]         lit_prod;
   logic [3:0]                lit;
   logic [BAR_W-1:0]          bar;
   logic [PROD_W+19:0]        tgt_prod;
   logic [PULSE_W-1:0]        tgt_drop;
   servo_ctl_type             servo_ctl;

   // ---------------- handshake ----------------
   assign out_load   = s2_v_ff && (!rsp_v_ff || rsp_tready);
   assign s2_load    = s1_v_ff && (!s2_v_ff || out_load);
   assign s1_load    = s0_v_ff && (!s1_v_ff || s2_load);
   assign req_tready = !s0_v_ff || s1_load;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s0_v_in  = req_fire ? 1'b1 : (s1_load  ? 1'b0 : s0_v_ff);
      s1_v_in  = s1_load  ? 1'b1 : (s2_load  ? 1'b0 : s1_v_ff);
      s2_v_in  = s2_load  ? 1'b1 : (out_load ? 1'b0 : s2_v_ff);
      rsp_v_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_v_ff);
   end

   // decode the item kind once at the input
   always_comb begin
      priority if (req_tuser[0] == REQ_FRAME) begin
         s0_op_in = OP_FRAME;
      end else if (req_tdata[TIME_W]) begin
         s0_op_in = OP_RISE;
      end else begin
         s0_op_in = OP_FALL;
      end
   end

   // ---------------- configuration ----------------
   always_comb begin
      slew_step_in = slew_step_ff;
      pulse_min_in = pulse_min_ff;
      pulse_max_in = pulse_max_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLEW_STEP: slew_step_in = csr_wdata[STEP_W-1:0];
            CSR_PULSE_MIN: pulse_min_in = csr_wdata[PULSE_W-1:0];
            CSR_PULSE_MAX: pulse_max_in = csr_wdata[PULSE_W-1:0];
            default:       ; // unmapped index, write dropped
         endcase
      end
   end

   // ---------------- stage 0 -> 1: width and cm ----------------
   // rise stamp lives here so a falling edge sees every earlier rising edge
   assign width   = s0_time_ff - rise_stamp_ff;
   assign cm_prod = {{17{1'b0}}, width} * {{TIME_W{1'b0}}, CM_RECIP};
   assign cm      = cm_prod[CM_SHIFT +: CM_W];

   assign rise_stamp_in = (s1_load && (s0_op_ff == OP_RISE)) ? s0_time_ff : rise_stamp_ff;

   // ---------------- stage 1 -> 2: clamp, bar, span product ----------------
   assign near_cm  = (s1_cm_ff > {3'b000, FULL_CM}) ? FULL_CM : s1_cm_ff[NEAR_W-1:0];
   assign far_cm   = FULL_CM - near_cm;
   assign span     = (pulse_max_ff >= pulse_min_ff) ? (pulse_max_ff - pulse_min_ff)
                                                    : {PULSE_W{1'b0}};
   assign prod     = {{PULSE_W{1'b0}}, near_cm} * {{NEAR_W{1'b0}}, span};
   assign lit_prod = {6'b000000, far_cm} * {{NEAR_W{1'b0}}, BAR_RECIP};
   assign lit      = lit_prod[BAR_SHIFT +: 4];

   // contiguous leds from bit zero
   always_comb begin
      for (int i = 0; i < BAR_W; i++) begin
         bar[i] = (4'(i) < lit);
      end
   end

   // ---------------- stage 2 -> result: target and state ----------------
   assign tgt_prod = {{20{1'b0}}, s2_prod_ff} * {{PROD_W{1'b0}}, TGT_RECIP};
   assign tgt_drop = tgt_prod[TGT_SHIFT +: PULSE_W];

   assign servo_ctl.load   = out_load;
   assign servo_ctl.op     = s2_op_ff;
   assign servo_ctl.target = pulse_max_ff - tgt_drop;

   always_comb begin
      last_width_in    = last_width_ff;
      last_distance_in = last_distance_ff;
      last_bar_in      = last_bar_ff;
      new_echo_in      = new_echo_ff;
      if (out_load) begin
         new_echo_in = (s2_op_ff == OP_FALL);
         if (s2_op_ff == OP_FALL) begin
            last_width_in    = s2_width_ff;
            last_distance_in = s2_cm_ff;
            last_bar_in      = s2_bar_ff;
         end
      end
   end

   ersg_servo u_servo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (servo_ctl),
      .slew_step (slew_step_ff),
      .pulse_now (pulse_now)
   );

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         slew_step_ff     <= SLEW_STEP_RESET;
         pulse_min_ff     <= PULSE_MIN_RESET;
         pulse_max_ff     <= PULSE_MAX_RESET;
         s0_v_ff          <= 1'b0;
         s1_v_ff          <= 1'b0;
         s2_v_ff          <= 1'b0;
         rsp_v_ff         <= 1'b0;
         rise_stamp_ff    <= '0;
         last_width_ff    <= '0;
         last_distance_ff <= '0;
         last_bar_ff      <= '0;
         new_echo_ff      <= 1'b0;
      end else begin
         slew_step_ff     <= slew_step_in;
         pulse_min_ff     <= pulse_min_in;
         pulse_max_ff     <= pulse_max_in;
         s0_v_ff          <= s0_v_in;
         s1_v_ff          <= s1_v_in;
         s2_v_ff          <= s2_v_in;
         rsp_v_ff         <= rsp_v_in;
         rise_stamp_ff    <= rise_stamp_in;
         last_width_ff    <= last_width_in;
         last_distance_ff <= last_distance_in;
         last_bar_ff      <= last_bar_in;
         new_echo_ff      <= new_echo_in;
      end
   end

   // payload stages, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_op_ff   <= s0_op_in;
         s0_time_ff <= req_tdata[TIME_W-1:0];
      end
      if (s1_load) begin
         s1_op_ff    <= s0_op_ff;
         s1_width_ff <= width;
         s1_cm_ff    <= cm;
      end
      if (s2_load) begin
         s2_op_ff    <= s1_op_ff;
         s2_width_ff <= s1_width_ff;
         s2_cm_ff    <= s1_cm_ff;
         s2_bar_ff   <= bar;
         s2_prod_ff  <= prod;
      end
   end

   // ---------------- outputs ----------------
   // state registers only change on a result load, so they serve as the result register
   assign rsp_tvalid   = rsp_v_ff;
   assign rsp_tuser[0] = new_echo_ff;
   assign rsp_tdata    = {1'b0, last_bar_ff, last_distance_ff, last_width_ff, pulse_now};

`ifndef SYNTH
   // bar is always a run of ones from bit zero
   a_bar_contiguous: assert property (@(posedge clock) disable iff (reset)
      (last_bar_ff & (last_bar_ff + 8'd1)) == 8'd0)
      else $error("bar leds not contiguous");

   // stored distance is the floor of width / 58
   a_distance_matches_width: assert property (@(posedge clock) disable iff (reset)
      ((17'(last_distance_ff) * 17'(US_PER_CM)) <= 17'(last_width_ff)) &&
      (17'(last_width_ff) < (17'(last_distance_ff) * 17'(US_PER_CM) + 17'(US_PER_CM))))
      else $error("distance does not match echo width");

   // echo edges never move the servo pulse
   a_edge_keeps_pulse: assert property (@(posedge clock) disable iff (reset)
      (out_load && (s2_op_ff != OP_FRAME)) |=> $stable(pulse_now))
      else $error("servo pulse moved on an echo edge");

   // result state only changes when a result is loaded
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable({last_width_ff, last_distance_ff, last_bar_ff, pulse_now}))
      else $error("result state changed without a result load");
`endif

endmodule

// ----- src/ersg_servo.sv -----
// ersg_servo: servo target and slew-limited pulse registers
// depends on ersg_pkg
`timescale 1ns / 1ps

module ersg_servo (
   input  logic                          clock,
   input  logic                          reset,
   input  ersg_pkg::servo_ctl_type       ctl,
   input  logic [ersg_pkg::STEP_W-1:0]   slew_step,
   output logic [ersg_pkg::PULSE_W-1:0]  pulse_now
);
   import ersg_pkg::*;

   logic [PULSE_W-1:0] target_ff, target_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;
   logic [PULSE_W-1:0] slewed;
   logic [PULSE_W:0]   now_up;
   logic [PULSE_W:0]   want_up;

   assign now_up  = {1'b0, pulse_ff} + {3'b000, slew_step};
   assign want_up = {1'b0, target_ff} + {3'b000, slew_step};

   // step toward the target, snap when within one step
   always_comb begin
      priority if ({1'b0, target_ff} > now_up) begin
         slewed = pulse_ff + {2'b00, slew_step};
      end else if (want_up < {1'b0, pulse_ff}) begin
         slewed = pulse_ff - {2'b00, slew_step};
      end else begin
         slewed = target_ff;
      end
   end

   always_comb begin
      target_in = target_ff;
      pulse_in  = pulse_ff;
      if (ctl.load && (ctl.op == OP_FALL)) begin
         target_in = ctl.target;
      end
      if (ctl.load && (ctl.op == OP_FRAME)) begin
         pulse_in = slewed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= MID_PULSE;
         pulse_ff  <= MID_PULSE;
      end else begin
         target_ff <= target_in;
         pulse_ff  <= pulse_in;
      end
   end

   assign pulse_now = pulse_ff;

endmodule
